FILE: src/crc8fc_pkg.sv
`timescale 1ns / 1ps
// crc8fc_pkg: shared types, codes and the byte-wide crc update for the
// crc8 frame checker. no dependencies.
package crc8fc_pkg;

  localparam logic [7:0] CRC_POLY = 8'h8C;

  typedef enum logic [1:0] {
    PH_CRC     = 2'd0,
    PH_SIZE    = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_CRC  = 2'd1,
    ST_SIZE = 2'd2
  } status_t;

  // frame tracking state
  typedef struct packed {
    phase_t     phase;
    logic [7:0] received_crc;
    logic [7:0] running_crc;
    logic [7:0] bytes_left;
    logic [7:0] frame_length;
    logic       oversize;
  } frame_state_t;

  // one result word, plus whether the byte produces one at all
  typedef struct packed {
    logic       has;
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       frame_end;
    status_t    status;
    logic [7:0] length;
  } frame_result_t;

  // reflected crc-8, lsb first, eight bit steps
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] crc;
    logic [7:0] d;
    crc = crc_in;
    d   = data;
    for (int k = 0; k < 8; k++) begin
      if (crc[0] ^ d[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
      d = d >> 1;
    end
    return crc;
  endfunction

endpackage

FILE: src/crc8fc_step.sv
`timescale 1ns / 1ps
// crc8fc_step: next-state and result logic for one received byte.
// depends on crc8fc_pkg.
module crc8fc_step (
  input  crc8fc_pkg::frame_state_t  cur,
  input  logic [7:0]                max_payload_bytes,
  input  logic [7:0]                rx_byte,
  output crc8fc_pkg::frame_state_t  nxt,
  output crc8fc_pkg::frame_result_t res
);
  import crc8fc_pkg::*;

  logic [7:0] crc_size;
  logic [7:0] crc_pay;
  logic [7:0] left_dec;
  logic       last;

  assign crc_size = crc8_byte(8'h00, rx_byte);
  assign crc_pay  = crc8_byte(cur.running_crc, rx_byte);
  assign left_dec = cur.bytes_left - 8'd1;
  assign last     = (left_dec == 8'd0);

  always_comb begin
    nxt = cur;
    res = '0;
    unique case (cur.phase)
      PH_SIZE: begin
        nxt.running_crc = crc_size;
        if (rx_byte == 8'd0) begin
          nxt.phase     = PH_CRC;
          res.has       = 1'b1;
          res.frame_end = 1'b1;
          res.status    = ST_SIZE;
        end else if (rx_byte == 8'd1) begin
          // empty payload, frame closes on the size byte
          nxt.phase     = PH_CRC;
          res.has       = 1'b1;
          res.frame_end = 1'b1;
          res.status    = (crc_size == cur.received_crc) ? ST_OK : ST_CRC;
        end else begin
          nxt.frame_length = rx_byte - 8'd1;
          nxt.bytes_left   = rx_byte - 8'd1;
          nxt.oversize     = ((rx_byte - 8'd1) > max_payload_bytes);
          nxt.phase        = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        nxt.running_crc = crc_pay;
        nxt.bytes_left  = left_dec;
        if (last) begin
          nxt.phase = PH_CRC;
        end
        if (cur.oversize) begin
          if (last) begin
            res.has       = 1'b1;
            res.frame_end = 1'b1;
            res.status    = ST_SIZE;
            res.length    = cur.frame_length;
          end
        end else begin
          res.has          = 1'b1;
          res.payload_byte = rx_byte;
          res.byte_valid   = 1'b1;
          if (last) begin
            res.frame_end = 1'b1;
            res.status    = (crc_pay == cur.received_crc) ? ST_OK : ST_CRC;
            res.length    = cur.frame_length;
          end
        end
      end
      default: begin
        // crc byte, also the unused phase code
        nxt.received_crc = rx_byte;
        nxt.running_crc  = 8'h00;
        nxt.phase        = PH_SIZE;
      end
    endcase
  end

endmodule

FILE: src/crc8_frame_checker.sv
`timescale 1ns / 1ps
// crc8_frame_checker: top level of the framed crc-8 receive checker.
// depends on crc8fc_pkg and crc8fc_step.
//
// usage
//  - input channel in_valid/in_ready carries one received byte per word
//    (rx_byte); a frame is [crc][size][payload], size counts itself
//  - output channel out_valid/out_ready carries one result word: a
//    payload byte passed through (byte_valid) and/or the frame close
//    (frame_end with frame_status and payload_length)
//  - crc and size bytes give no word, except a size byte that closes the
//    frame; bytes of an oversize frame give no word until its last one
//  - cfg_we/cfg_wdata write max_payload_bytes; write only while idle
//  - throughput: one byte per cycle while no result word is held up, set
//    by the byte-wide crc update and state step between the input register
//    and the result register, which drives out_valid
//  - reset (rst, synchronous): both registers empty, frame state back to
//    waiting for the crc byte, max_payload_bytes back to 254
//  - receiver stall: the result word holds; the input register still
//    takes bytes that give no word, and takes one more byte while a
//    result waits, then in_ready drops
module crc8_frame_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] payload_byte,
  output logic       byte_valid,
  output logic       frame_end,
  output logic [1:0] frame_status,
  output logic [7:0] payload_length
);
  import crc8fc_pkg::*;

  logic [7:0]    max_payload_bytes;
  frame_state_t  fstate;
  frame_state_t  fstate_next;
  frame_result_t step_res;

  // input register
  logic          s1_valid;
  logic [7:0]    s1_byte;

  // result register
  frame_result_t out_word;

  logic          out_free;
  logic          advance;

  crc8fc_step u_step (
    .cur               (fstate),
    .max_payload_bytes (max_payload_bytes),
    .rx_byte           (s1_byte),
    .nxt               (fstate_next),
    .res               (step_res)
  );

  // byte leaves the input register when it needs no slot or a slot is free
  assign out_free = !out_valid || out_ready;
  assign advance  = s1_valid && (out_free || !step_res.has);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_bytes <= 8'd254;
    end else if (cfg_we) begin
      max_payload_bytes <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= rx_byte;
    end
  end

  // frame state moves on each consumed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      fstate <= '{phase: PH_CRC, received_crc: 8'h00, running_crc: 8'h00,
                  bytes_left: 8'h00, frame_length: 8'h00, oversize: 1'b0};
    end else if (advance) begin
      fstate <= fstate_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && step_res.has) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_res.has) begin
      out_word <= step_res;
    end
  end

  assign payload_byte   = out_word.payload_byte;
  assign byte_valid     = out_word.byte_valid;
  assign frame_end      = out_word.frame_end;
  assign frame_status   = out_word.status;
  assign payload_length = out_word.length;

  // input side only stalls behind a held byte
  a_ready_low_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid)
    else $error("in_ready low with empty input register");

  // status and length are only carried on the closing word
  a_quiet_fields_mid_frame: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !frame_end) |-> (frame_status == ST_OK && payload_length == 8'd0))
    else $error("status or length set on a non-closing word");

  // a passed-through byte never closes a frame as bad size
  a_no_bytes_in_bad_size: assert property (@(posedge clk) disable iff (rst)
    (out_valid && byte_valid) |-> (frame_status != ST_SIZE))
    else $error("payload byte passed out with bad size status");

  // a result word is never overwritten while it waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !(advance && step_res.has))
    else $error("result register loaded while stalled");

endmodule

FILE: test/tb_crc8_frame_checker.sv
`timescale 1ns / 1ps
// tb_crc8_frame_checker: self-checking testbench for the crc8 frame checker.
// depends on crc8fc_pkg and crc8_frame_checker; a local frame predictor
// checks every result word, with random idling on both channels.
module tb_crc8_frame_checker;
  import crc8fc_pkg::*;

  localparam int STALL_LIMIT = 2000;  // cycles with no word moving on either side
  localparam int LONG_HOLD   = 80;    // receiver hold-off, fills the block
  localparam int ITEM_TARGET = 1750;

  // one expected result word
  typedef struct packed {
    logic [7:0] pbyte;
    logic       has_byte;
    logic       closes;
    status_t    status;
    logic [7:0] length;
  } frame_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] payload_byte;
  logic       byte_valid;
  logic       frame_end;
  logic [1:0] frame_status;
  logic [7:0] payload_length;

  crc8_frame_checker DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .payload_byte  (payload_byte),
    .byte_valid    (byte_valid),
    .frame_end     (frame_end),
    .frame_status  (frame_status),
    .payload_length(payload_length)
  );

  always #5 clk = ~clk;

  // stimulus and expectation stores
  logic [7:0]  tx_bytes[$];        // bytes waiting to be offered
  frame_word_t expected_words[$];  // predicted result words, oldest first
  int          bytes_queued = 0;
  int          bytes_taken = 0;
  int          mismatches = 0;

  // idling controls, changed per phase by the stimulus block
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  int hold_req = 0;  // bumped to ask the receiver for a long hold-off

  // predictor state, mirrors the frame tracking of the block
  phase_t     cur_phase = PH_CRC;
  logic [7:0] rcv_crc = 8'd0;
  logic [7:0] run_crc = 8'd0;
  logic [7:0] left = 8'd0;
  logic [7:0] frame_len = 8'd0;
  logic       oversize = 1'b0;
  logic [7:0] max_len = 8'd254;

  // reflected crc-8: fold the byte in, then eight shift steps
  function automatic logic [7:0] crc8_step(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] r;
    r = crc_in ^ data;
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  // advance the frame predictor by one accepted byte
  task automatic predict_byte(input logic [7:0] b);
    frame_word_t w;
    logic        last;
    w = '0;
    case (cur_phase)
      PH_SIZE: begin
        run_crc = crc8_step(8'h00, b);
        if (b == 8'd0 || b == 8'd1) begin
          // size zero is always bad; size one is an empty payload judged by crc
          cur_phase = PH_CRC;
          w.closes = 1'b1;
          if (b == 8'd0) w.status = ST_SIZE;
          else w.status = (run_crc == rcv_crc) ? ST_OK : ST_CRC;
          expected_words.push_back(w);
        end else begin
          frame_len = b - 8'd1;
          left      = frame_len;
          oversize  = (frame_len > max_len);
          cur_phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        run_crc = crc8_step(run_crc, b);
        left    = left - 8'd1;
        last    = (left == 8'd0);
        if (last) cur_phase = PH_CRC;
        if (oversize) begin
          // swallowed payload, only the last byte closes the frame
          if (last) begin
            w.closes = 1'b1;
            w.status = ST_SIZE;
            w.length = frame_len;
            expected_words.push_back(w);
          end
        end else begin
          w.pbyte    = b;
          w.has_byte = 1'b1;
          if (last) begin
            w.closes = 1'b1;
            w.status = (run_crc == rcv_crc) ? ST_OK : ST_CRC;
            w.length = frame_len;
          end
          expected_words.push_back(w);
        end
      end
      default: begin
        rcv_crc   = b;
        run_crc   = 8'd0;
        cur_phase = PH_SIZE;
      end
    endcase
  endtask

  // sender: one word per handshake, random gap after each word
  int tx_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      rx_byte  <= 8'd0;
      tx_gap   <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_byte(rx_byte);
        bytes_taken++;
      end
      // slot is free when nothing is offered or the offer was just taken
      if (!in_valid || in_ready) begin
        if (tx_gap != 0) begin
          tx_gap   <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (tx_bytes.size() != 0) begin
          rx_byte  <= tx_bytes.pop_front();
          in_valid <= 1'b1;
          tx_gap   <= tx_idle_en ? int'($urandom_range(0, 3)) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic note_mismatch(input string field, input int exp_v, input int act_v);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
    mismatches++;
  endtask

  // receiver: checks each result word, stalls at random or on a long hold request
  int rx_wait = 0;
  int hold_seen = 0;
  always @(posedge clk) begin : rx_side
    int          n;
    frame_word_t w;
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait   <= 0;
      hold_seen <= 0;
    end else begin
      n = rx_wait;
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: result word with nothing expected, expected none, actual %0h %0b %0b %0d %0d",
                   $time, payload_byte, byte_valid, frame_end, frame_status, payload_length);
          mismatches++;
        end else begin
          w = expected_words.pop_front();
          if (payload_byte !== w.pbyte) note_mismatch("payload_byte", w.pbyte, payload_byte);
          if (byte_valid !== w.has_byte) note_mismatch("byte_valid", w.has_byte, byte_valid);
          if (frame_end !== w.closes) note_mismatch("frame_end", w.closes, frame_end);
          if (frame_status !== w.status) note_mismatch("frame_status", w.status, frame_status);
          if (payload_length !== w.length)
            note_mismatch("payload_length", w.length, payload_length);
        end
        n = rx_idle_en ? int'($urandom_range(0, 3)) : 0;
      end else if (n > 0) begin
        n--;
      end
      if (hold_req != hold_seen) begin
        n = LONG_HOLD;
        hold_seen <= hold_req;
      end
      rx_wait   <= n;
      out_ready <= (n == 0);
    end
  end

  // watchdog: ends the run when no word moves for too long
  int stall_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic queue_byte(input logic [7:0] b);
    tx_bytes.push_back(b);
    bytes_queued++;
  endtask

  // [crc][size][payload]; corner payload alternates 00 and ff
  task automatic queue_frame(input int unsigned size, input bit bad_crc, input bit corner);
    logic [7:0] c;
    logic [7:0] d;
    logic [7:0] pay[$];
    c = crc8_step(8'h00, size[7:0]);
    for (int k = 1; k < int'(size); k++) begin
      d = corner ? (k[0] ? 8'h00 : 8'hFF) : 8'($urandom_range(0, 255));
      pay.push_back(d);
      c = crc8_step(c, d);
    end
    if (bad_crc) c = c ^ (8'h01 << $urandom_range(0, 7));
    queue_byte(c);
    queue_byte(size[7:0]);
    foreach (pay[k]) queue_byte(pay[k]);
  endtask

  // block until every byte is taken and every word is back, then let the
  // pipeline empty of bytes that give no word
  task automatic wait_drained();
    while (bytes_taken != bytes_queued || expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max(input logic [7:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    max_len    = v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int          p;
    int          phase_start;
    int unsigned r;
    int unsigned sz;
    logic [7:0]  mx;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: size zero, empty payloads good and bad, extreme bytes, crc error
    queue_frame(0, 1'b0, 1'b0);
    queue_frame(1, 1'b0, 1'b0);
    queue_frame(1, 1'b1, 1'b0);
    queue_frame(3, 1'b0, 1'b1);
    queue_frame(4, 1'b1, 1'b1);
    wait_drained();

    // register at zero: any payload is oversize, empty payload still judged
    write_max(8'd0);
    queue_frame(2, 1'b0, 1'b0);
    queue_frame(1, 1'b0, 1'b0);
    wait_drained();

    // limit of one: one byte passes, two bytes are swallowed
    write_max(8'd1);
    queue_frame(2, 1'b0, 1'b1);
    queue_frame(3, 1'b0, 1'b0);
    wait_drained();

    // random phases, each under its own limit and idling mix
    p = 0;
    while (bytes_queued < ITEM_TARGET) begin
      case (p % 6)
        0: mx = 8'd254;
        1: mx = 8'd1;
        2: mx = 8'($urandom_range(2, 253));
        3: mx = 8'd8;
        4: mx = 8'd253;
        default: mx = 8'($urandom_range(1, 254));
      endcase
      write_max(mx);
      tx_idle_en = ($urandom_range(0, 2) != 0);
      rx_idle_en = ($urandom_range(0, 2) != 0);
      // long receiver hold-off while the sender keeps offering
      if (p % 4 == 2) hold_req++;
      phase_start = bytes_queued;
      while (bytes_queued - phase_start < 150) begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          queue_frame($urandom_range(2, 9), $urandom_range(0, 3) == 0, 1'b0);
        end else if (r < 75) begin
          // payload right at the limit, one under or one over
          sz = int'(mx) + $urandom_range(0, 2);
          if (sz < 2) sz = 2;
          if (sz > 255) sz = 255;
          queue_frame(sz, $urandom_range(0, 3) == 0, 1'b0);
        end else if (r < 78) begin
          queue_frame(255, $urandom_range(0, 3) == 0, 1'b0);
        end else if (r < 88) begin
          queue_frame($urandom_range(0, 1), $urandom_range(0, 1) == 1, 1'b0);
        end else begin
          // stray bytes, breaks the framing until it falls back in step
          repeat ($urandom_range(1, 4)) queue_byte(8'($urandom_range(0, 255)));
        end
      end
      wait_drained();
      p++;
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
